/* hdl/stok_pkg.sv */
// Shared types, character codes and scan modes of the script tokenizer.
`timescale 1ns / 1ps

package stok_pkg;

   localparam logic [2:0] MODE_SKIP    = 3'd0;
   localparam logic [2:0] MODE_SLASH   = 3'd1;
   localparam logic [2:0] MODE_COMMENT = 3'd2;
   localparam logic [2:0] MODE_QUOTE   = 3'd3;
   localparam logic [2:0] MODE_QBACK   = 3'd4;
   localparam logic [2:0] MODE_WORD    = 3'd5;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_COMMA     = 8'h2c;
   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7b;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7d;

   localparam int RESULT_DEPTH = 3;

   localparam logic [2:0] ADDR_LINE_MODE = 3'd0;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] token_byte;
      logic       token_end;
      logic       input_end;
   } result_type;

   function automatic logic is_single(input logic [7:0] c);
      is_single = (c == CHAR_LBRACE) || (c == CHAR_RBRACE) || (c == CHAR_RPAREN) ||
                  (c == CHAR_LPAREN) || (c == CHAR_SQUOTE) || (c == CHAR_COMMA);
   endfunction

   function automatic result_type make_result(input logic has, input logic [7:0] c,
                                              input logic tend, input logic iend);
      result_type r;
      r.has_byte   = has;
      r.token_byte = has ? c : 8'd0;
      r.token_end  = tend;
      r.input_end  = iend;
      make_result  = r;
   endfunction

endpackage

/* hdl/script_tokenizer.sv */
// Top level of the script tokenizer: scan logic, result queue and register port.
`timescale 1ns / 1ps

// The tokenizer takes one text byte per item and returns zero to two result items
// for it, with last marking the final one of each byte. A byte that gives at most one
// result is taken in every cycle while the result side keeps up. A byte that gives two
// results holds the input back, because the result queue drains one item per cycle
// while rsp_ready is high and the next byte enters only as its last entry leaves.
// The scan logic sits between the input port and a three-entry result register.
module script_tokenizer
   import stok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_byte,
   output logic [7:0]  rsp_token_byte,
   output logic        rsp_token_end,
   output logic        rsp_input_end,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [2:0]  mode_ff, mode_in;
   logic        line_mode_ff;
   logic [1:0]  cnt_ff, cnt_in;
   result_type  queue_ff [RESULT_DEPTH];
   result_type  queue_in [RESULT_DEPTH];
   result_type  res      [RESULT_DEPTH];
   logic [1:0]  num;
   logic        do_word, word_hp, do_quote, quote_hp;
   logic [7:0]  c;
   logic        accept, pop;

   assign c          = req_text_byte;
   assign req_ready  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = cnt_ff != 2'd0;
   assign pop        = rsp_valid && rsp_ready;

   assign rsp_has_byte   = queue_ff[0].has_byte;
   assign rsp_token_byte = queue_ff[0].token_byte;
   assign rsp_token_end  = queue_ff[0].token_end;
   assign rsp_input_end  = queue_ff[0].input_end;
   assign rsp_last       = cnt_ff == 2'd1;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_LINE_MODE[2]) ? {31'd0, line_mode_ff} : 32'd0;

   always_comb begin
      num      = 2'd0;
      mode_in  = mode_ff;
      do_word  = 1'b0;
      word_hp  = 1'b0;
      do_quote = 1'b0;
      quote_hp = 1'b0;
      for (int i = 0; i < RESULT_DEPTH; i++) begin
         res[i] = make_result(1'b0, CHAR_NUL, 1'b0, 1'b0);
      end
      unique case (mode_ff)
         MODE_SLASH: begin
            if (c == CHAR_SLASH) begin
               mode_in = MODE_COMMENT;
            end else begin
               do_word = 1'b1;
               word_hp = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (c == CHAR_NUL) begin
               res[num] = make_result(1'b0, CHAR_NUL, 1'b0, 1'b1);
               num      = num + 2'd1;
               mode_in  = MODE_SKIP;
            end else if (c == CHAR_NEWLINE) begin
               mode_in = MODE_SKIP;
            end
         end
         MODE_QUOTE: begin
            do_quote = 1'b1;
         end
         MODE_QBACK: begin
            if (c == CHAR_DQUOTE) begin
               res[num] = make_result(1'b1, CHAR_DQUOTE, 1'b0, 1'b0);
               num      = num + 2'd1;
               mode_in  = MODE_QUOTE;
            end else begin
               do_quote = 1'b1;
               quote_hp = 1'b1;
            end
         end
         MODE_WORD: begin
            do_word = 1'b1;
         end
         default: begin
            mode_in = MODE_SKIP;
            if (c == CHAR_NUL) begin
               res[num] = make_result(1'b0, CHAR_NUL, 1'b0, 1'b1);
               num      = num + 2'd1;
            end else if (c <= CHAR_SPACE) begin
               mode_in = MODE_SKIP;
            end else if (c == CHAR_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (c == CHAR_DQUOTE) begin
               mode_in = MODE_QUOTE;
            end else if (is_single(c)) begin
               res[num] = make_result(1'b1, c, 1'b1, 1'b0);
               num      = num + 2'd1;
            end else begin
               res[num] = make_result(1'b1, c, 1'b0, 1'b0);
               num      = num + 2'd1;
               mode_in  = MODE_WORD;
            end
         end
      endcase

      if (do_word) begin
         if (is_single(c)) begin
            res[num] = make_result(word_hp, CHAR_SLASH, 1'b1, 1'b0);
            num      = num + 2'd1;
            res[num] = make_result(1'b1, c, 1'b1, 1'b0);
            num      = num + 2'd1;
            mode_in  = MODE_SKIP;
         end else if ((c != CHAR_NUL) &&
                      ((c > CHAR_SPACE) || (line_mode_ff && (c == CHAR_SPACE)))) begin
            if (word_hp) begin
               res[num] = make_result(1'b1, CHAR_SLASH, 1'b0, 1'b0);
               num      = num + 2'd1;
            end
            res[num] = make_result(1'b1, c, 1'b0, 1'b0);
            num      = num + 2'd1;
            mode_in  = MODE_WORD;
         end else begin
            res[num] = make_result(word_hp, CHAR_SLASH, 1'b1, 1'b0);
            num      = num + 2'd1;
            if (c == CHAR_NUL) begin
               res[num] = make_result(1'b0, CHAR_NUL, 1'b0, 1'b1);
               num      = num + 2'd1;
            end
            mode_in = MODE_SKIP;
         end
      end

      if (do_quote) begin
         if (c == CHAR_NUL) begin
            res[num] = make_result(quote_hp, CHAR_BACKSLASH, 1'b1, 1'b0);
            num      = num + 2'd1;
            res[num] = make_result(1'b0, CHAR_NUL, 1'b0, 1'b1);
            num      = num + 2'd1;
            mode_in  = MODE_SKIP;
         end else begin
            if (quote_hp) begin
               res[num] = make_result(1'b1, CHAR_BACKSLASH, 1'b0, 1'b0);
               num      = num + 2'd1;
            end
            if (c == CHAR_BACKSLASH) begin
               mode_in = MODE_QBACK;
            end else if (c == CHAR_DQUOTE) begin
               res[num] = make_result(1'b0, CHAR_NUL, 1'b1, 1'b0);
               num      = num + 2'd1;
               mode_in  = MODE_SKIP;
            end else begin
               res[num] = make_result(1'b1, c, 1'b0, 1'b0);
               num      = num + 2'd1;
               mode_in  = MODE_QUOTE;
            end
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < RESULT_DEPTH; i++) begin
         queue_in[i] = queue_ff[i];
      end
      if (accept) begin
         cnt_in = num;
         for (int i = 0; i < RESULT_DEPTH; i++) begin
            queue_in[i] = res[i];
         end
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         for (int i = 0; i < RESULT_DEPTH - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SKIP;
         cnt_ff       <= 2'd0;
         line_mode_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            mode_ff <= mode_in;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             (csr_paddr[2] == ADDR_LINE_MODE[2])) begin
            line_mode_ff <= csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RESULT_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

endmodule
